[rtl/dwnt_pkg.sv]
// Shared types, constants and helpers for the DNS wire-name to text block.
package dwnt_pkg;

	localparam logic [7:0] DOT_CHAR  = 8'h2E;
	localparam logic [7:0] NUL_CHAR  = 8'h00;
	localparam logic [7:0] UPPER_A   = 8'h41;
	localparam logic [7:0] UPPER_Z   = 8'h5A;
	localparam logic [7:0] CASE_STEP = 8'h20;

	// One step of the decoder: whether a result comes out, and its fields.
	typedef struct packed {
		logic       emit;
		logic [7:0] text_char;
		logic       end_of_name;
		logic       too_long;
	} step_res_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_STEP;
		end
		return r;
	endfunction

endpackage

[rtl/dwnt_if.sv]
// Handshake channels: wire bytes in, text characters out.
interface dwnt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;

	modport source (output valid, output wire_byte, input ready);
	modport sink (input valid, input wire_byte, output ready);
endinterface

interface dwnt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       end_of_name;
	logic       too_long;

	modport source (output valid, output text_char, output end_of_name, output too_long,
		input ready);
	modport sink (input valid, input text_char, input end_of_name, input too_long,
		output ready);
endinterface

[rtl/dwnt_decode.sv]
// Per-name decode state and the single-step decode of one wire byte.
module dwnt_decode #(
	parameter int MAX_NAME_LENGTH = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  logic [7:0]          byte_s1,
	input  logic                advance,
	output dwnt_pkg::step_res_t res
);
	import dwnt_pkg::*;

	localparam int CntW = $clog2(MAX_NAME_LENGTH + 1);
	localparam logic [CntW:0] MaxCnt = (CntW + 1)'(MAX_NAME_LENGTH);

	logic [7:0]      left_q, left_d;
	logic            first_q, first_d;
	logic [CntW-1:0] seen_q, seen_d;
	logic [CntW:0]   count;

	always_comb begin
		count   = {1'b0, seen_q} + (CntW + 1)'(1);
		left_d  = left_q;
		first_d = first_q;
		seen_d  = seen_q;
		res     = '{emit: 1'b0, text_char: NUL_CHAR, end_of_name: 1'b0, too_long: 1'b0};
		priority if (count > MaxCnt) begin
			// overlong name: flag it, drop the byte, start afresh
			res     = '{emit: 1'b1, text_char: NUL_CHAR, end_of_name: 1'b1, too_long: 1'b1};
			left_d  = '0;
			first_d = 1'b1;
			seen_d  = '0;
		end else if (left_q != '0) begin
			res.emit      = 1'b1;
			res.text_char = to_lower(byte_s1);
			left_d        = left_q - 8'd1;
			seen_d        = count[CntW-1:0];
		end else if (byte_s1 == NUL_CHAR) begin
			res.emit        = 1'b1;
			res.end_of_name = 1'b1;
			left_d          = '0;
			first_d         = 1'b1;
			seen_d          = '0;
		end else begin
			// length byte: a dot for every label but the first
			res.emit      = !first_q;
			res.text_char = DOT_CHAR;
			left_d        = byte_s1;
			first_d       = 1'b0;
			seen_d        = count[CntW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			first_q <= 1'b1;
			seen_q  <= '0;
		end else if (valid_s1 && advance) begin
			left_q  <= left_d;
			first_q <= first_d;
			seen_q  <= seen_d;
		end
	end

endmodule

[rtl/dns_wire_name_to_text_core.sv]
// Top level: DNS wire-format name to lowercased dotted text, one byte a beat.
//
//   channel    dir   beat contents
//   wire_in    in    wire_byte (length or label byte)
//   text_out   out   text_char, end_of_name, too_long
//
// Cycles: one byte a cycle while text_out is not back-pressured; a byte is
// registered in stage 1, decoded against the per-name counters, and its
// result is registered in the output register. The decode (counter
// increment, compares, lowercase) is combinational.
// Reset: arst_n clears the stage valids and the per-name state (no label
// open, first label pending, zero bytes seen).
// Stalls: a length byte of the first label gives no beat and advances even
// while the output register is full; any other byte waits in stage 1 until
// the output register is empty or being taken.
module dns_wire_name_to_text_core #(
	parameter int MAX_NAME_LENGTH = 255
) (
	input logic          clk,
	input logic          arst_n,
	dwnt_byte_if.sink    wire_in,
	dwnt_char_if.source  text_out
);
	import dwnt_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      out_valid_q;
	logic [7:0] out_char_q;
	logic      out_eon_q;
	logic      out_long_q;
	logic      out_free;
	logic      advance;
	step_res_t res;

	// Output slot is free when empty or being taken this cycle.
	assign out_free = !out_valid_q || text_out.ready;
	// Advance stage 1 if it needs no slot, or the slot frees up.
	assign advance  = !res.emit || out_free;
	assign wire_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (wire_in.ready) begin
			valid_s1 <= wire_in.valid;
		end
	end

	// Hold the byte while stalled.
	always_ff @(posedge clk) begin
		if (wire_in.ready && wire_in.valid) begin
			byte_s1 <= wire_in.wire_byte;
		end
	end

	dwnt_decode #(
		.MAX_NAME_LENGTH(MAX_NAME_LENGTH)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.advance  (advance),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && res.emit) begin
			out_char_q <= res.text_char;
			out_eon_q  <= res.end_of_name;
			out_long_q <= res.too_long;
		end
	end

	assign text_out.valid       = out_valid_q;
	assign text_out.text_char   = out_char_q;
	assign text_out.end_of_name = out_eon_q;
	assign text_out.too_long    = out_long_q;

	// An overflow beat always closes the name with a NUL.
	a_long_ends: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && text_out.too_long |-> text_out.end_of_name &&
		text_out.text_char == NUL_CHAR)
		else $error("too_long beat not a terminating NUL");

	// Input back-pressure only comes from a held byte in stage 1.
	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		!wire_in.ready |-> valid_s1 && out_valid_q && !text_out.ready)
		else $error("input stalled without a blocked byte");

	// A taken byte that needs no slot never leaves stage 1 stuck.
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res.emit |-> wire_in.ready)
		else $error("silent byte stalled stage 1");

endmodule
